// ===== hw/rtl/wildcard_byte_pattern_scanner_top_assert.svh =====
// assertion macros used by the scanner checker
// expects clk and rst_n to be visible where a macro is used
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_TOP_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define WBPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps check failed");

// consequent must hold in the cycle after the antecedent
`define WBPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps check failed");

`endif

// ===== hw/rtl/wbps_pkg.sv =====
// types and constants of the wildcard byte pattern scanner
// no dependencies
package wbps_pkg;

    localparam int PAT_BYTES    = 32;
    localparam int LEN_W        = 6;
    localparam int OUT_OFFSET_W = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_0,
        REG_PATTERN_1,
        REG_PATTERN_2,
        REG_PATTERN_3,
        REG_CARE_MASK,
        REG_PATTERN_LENGTH
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] match_offset;
    } result_item_t;

    typedef struct packed {
        logic [PAT_BYTES-1:0][7:0] pattern_bytes;
        logic [PAT_BYTES-1:0]      care_mask;
        logic [LEN_W-1:0]          pattern_length;
    } cfg_t;

endpackage

// ===== hw/rtl/wildcard_byte_pattern_scanner_top.sv =====
// wildcard byte pattern scanner, top level; depends on wbps_pkg, wbps_cfg, wbps_cell
// an accepted byte enters the compare stage, then its result the output register
// throughput: one byte per cycle; the compare across the cell row sets this figure
// a stalled result blocks a new byte only when the byte behind it also has a result
// reset: async active low, clears registers, window, offset count and match flag
module wildcard_byte_pattern_scanner_top
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 32,
    parameter int OFFSET_BITS       = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // byte items in
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  byte_item_t             byte_item,
    // result items out
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_item_t           result_item,
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // longest usable pattern: the smaller of register space and window depth
    localparam int EFF_MAX = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES : PAT_BYTES;

    cfg_t                     cfg;
    logic [LEN_W-1:0]         eff_len;

    // window chain
    logic [MAX_PATTERN_BYTES-1:0][7:0] win;
    logic [MAX_PATTERN_BYTES-1:0]      hits;

    // byte counter of the current region
    logic [OFFSET_BITS-1:0]   seen_reg;
    logic [OFFSET_BITS-1:0]   seen_next;
    logic [OFFSET_BITS-1:0]   seen_inc;

    // compare stage
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic                     s1_last_reg;
    logic [OFFSET_BITS-1:0]   s1_seen_reg;
    logic                     finished_reg;
    logic                     finished_next;

    // output register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    result_item_t             out_reg;
    result_item_t             out_next;

    logic                     byte_fire;
    logic                     s1_advance;
    logic                     len_ok;
    logic                     match;
    logic                     produce;
    logic [OFFSET_BITS-1:0]   start_pos;

    wbps_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // clamp the length to what the window can hold
    assign eff_len = (cfg.pattern_length > LEN_W'(EFF_MAX)) ? LEN_W'(EFF_MAX)
                                                           : cfg.pattern_length;

    // row of cells, newest byte in cell 0, each byte moves one cell per accepted item
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++)
    begin : g_cell
        logic [7:0] cell_in;

        if (k == 0)
        begin : g_head
            assign cell_in = byte_item.data_byte;
        end
        else
        begin : g_body
            assign cell_in = win[k-1];
        end

        wbps_cell #(
            .IDX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (byte_fire),
            .win_in   (cell_in),
            .cfg      (cfg),
            .eff_len  (eff_len),
            .win_out  (win[k]),
            .hit      (hits[k])
        );
    end

    // handshake
    assign byte_fire  = byte_valid && byte_ready;
    assign byte_ready = !s1_valid_reg || s1_advance;

    // offset count saturates at all ones
    assign seen_inc  = (seen_reg == '1) ? seen_reg : seen_reg + OFFSET_BITS'(1);
    assign seen_next = byte_fire ? (byte_item.last_byte ? '0 : seen_inc) : seen_reg;

    // compare stage decision, taken on the window as it stands after the byte
    assign len_ok    = (eff_len != '0) && (s1_seen_reg >= OFFSET_BITS'(eff_len));
    assign match     = !finished_reg && len_ok && (&hits);
    assign produce   = s1_valid_reg && (match || (!finished_reg && s1_last_reg));
    assign start_pos = s1_seen_reg - OFFSET_BITS'(eff_len);

    // an item with no result never waits on the output
    assign s1_advance = s1_valid_reg && (!produce || !out_valid_reg || result_ready);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (byte_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // once found, the rest of the region is ignored until its last byte
    always_comb
    begin
        finished_next = finished_reg;
        if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                finished_next = 1'b0;
            end
            else if (match)
            begin
                finished_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (s1_advance && produce)
        begin
            out_valid_next        = 1'b1;
            out_next.found        = match;
            out_next.match_offset = match ? OUT_OFFSET_W'(start_pos) : '0;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            s1_valid_reg  <= s1_valid_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload of the compare stage and the output
    always_ff @(posedge clk)
    begin
        if (byte_fire)
        begin
            s1_last_reg <= byte_item.last_byte;
            s1_seen_reg <= seen_inc;
        end
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

endmodule

// ===== hw/rtl/wbps_cfg.sv =====
// configuration register file of the scanner
// depends on wbps_pkg
module wbps_cfg
    import wbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PATTERN_0:      cfg_next.pattern_bytes[7:0]   = cfg_data;
                REG_PATTERN_1:      cfg_next.pattern_bytes[15:8]  = cfg_data;
                REG_PATTERN_2:      cfg_next.pattern_bytes[23:16] = cfg_data;
                REG_PATTERN_3:      cfg_next.pattern_bytes[31:24] = cfg_data;
                REG_CARE_MASK:      cfg_next.care_mask = cfg_data[PAT_BYTES-1:0];
                REG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_data[LEN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/wbps_cell.sv =====
// one window cell: holds a byte, its aligned pattern byte and care bit
// depends on wbps_pkg
module wbps_cell
    import wbps_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic [7:0]       win_in,
    input  cfg_t             cfg,
    input  logic [LEN_W-1:0] eff_len,
    output logic [7:0]       win_out,
    output logic             hit
);

    localparam logic [LEN_W:0] IDX_V = (LEN_W+1)'(IDX);

    logic [7:0]       win_reg;
    logic [7:0]       pat_reg;
    logic [7:0]       pat_next;
    logic             care_reg;
    logic             care_next;
    logic [LEN_W-1:0] pat_pos;
    logic             in_use;

    // pattern byte that lines up with this cell is len-1-idx
    assign in_use  = {1'b0, eff_len} > IDX_V;
    assign pat_pos = eff_len - LEN_W'(1) - IDX_V[LEN_W-1:0];

    always_comb
    begin
        pat_next  = cfg.pattern_bytes[pat_pos[LEN_W-2:0]];
        care_next = in_use && cfg.care_mask[pat_pos[LEN_W-2:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            care_reg <= 1'b0;
        end
        else
        begin
            care_reg <= care_next;
            if (shift_en)
            begin
                win_reg <= win_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    assign win_out = win_reg;
    assign hit     = !care_reg || (win_reg == pat_reg);

endmodule

// ===== hw/rtl/wbps_checker.sv =====
// port level checks of the scanner, bound to the top level
// depends on wbps_pkg and wildcard_byte_pattern_scanner_top_assert.svh
`include "wildcard_byte_pattern_scanner_top_assert.svh"

module wbps_checker
    import wbps_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   byte_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input result_item_t           result_item,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    // a result waiting for the sink keeps its value
    `WBPS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_item))

    // not found carries a zero offset
    `WBPS_ASSERT_NOW(a_miss_zero, result_valid && !result_item.found, result_item.match_offset == '0)

    // input stalls only behind a blocked result
    `WBPS_ASSERT_NOW(a_stall_cause, !byte_ready, result_valid && !result_ready)

    // register writes are never held off
    `WBPS_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (.*);

// ===== verif/testbench.sv =====
// self-checking testbench for wildcard_byte_pattern_scanner_top
// depends on wbps_pkg and the scanner rtl; needs no files or arguments at run time
// a scoreboard class predicts each result from the accepted bytes and register writes
`timescale 1ns / 100ps

module testbench;
    import wbps_pkg::*;

    // window model is sized to the default MAX_PATTERN_BYTES of the dut
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 4;
    localparam int RANDOM_BYTES    = 1550;
    localparam int PHASE_BYTES     = 110;
    localparam int BURST_REGIONS   = 24;

    // register slots past the end of the list; writes there must not land anywhere
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = CFG_INDEX_W'(6);
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = CFG_INDEX_W'(7);

    // predicts scanner results from accepted bytes and register writes
    class scan_scoreboard;
        logic [7:0]              pat [PAT_BYTES];
        logic [PAT_BYTES-1:0]    care;
        logic [LEN_W-1:0]        plen;
        logic [7:0]              window [PAT_BYTES];
        logic [OUT_OFFSET_W-1:0] seen;
        bit                      finished;
        result_item_t            awaited_results [$];
        int                      errors;

        function new();
            foreach (pat[j]) pat[j] = 8'h00;
            care   = '0;
            plen   = '0;
            errors = 0;
            clear_region();
        endfunction

        function void clear_region();
            foreach (window[k]) window[k] = 8'h00;
            seen     = '0;
            finished = 1'b0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3:
                    for (int b = 0; b < 8; b++)
                        pat[int'(idx) * 8 + b] = data[8 * b +: 8];
                REG_CARE_MASK:      care = data[PAT_BYTES-1:0];
                REG_PATTERN_LENGTH: plen = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_byte(byte_item_t it);
            int           eff;
            bit           hit;
            result_item_t r;
            if (!finished)
            begin
                eff = (plen > PAT_BYTES) ? PAT_BYTES : int'(plen);
                for (int k = PAT_BYTES - 1; k > 0; k--)
                    window[k] = window[k - 1];
                window[0] = it.data_byte;
                if (seen != '1)
                    seen = seen + 1'b1;
                // pattern byte 0 lines up with the oldest byte of the span
                hit = (eff != 0) && (seen >= OUT_OFFSET_W'(eff));
                for (int j = 0; j < eff; j++)
                    if (care[j] && window[eff - 1 - j] != pat[j])
                        hit = 1'b0;
                if (hit)
                begin
                    r.found         = 1'b1;
                    r.match_offset  = seen - OUT_OFFSET_W'(eff);
                    finished        = 1'b1;
                    awaited_results = {awaited_results, r};
                end
                else if (it.last_byte)
                begin
                    r.found         = 1'b0;
                    r.match_offset  = '0;
                    awaited_results = {awaited_results, r};
                end
            end
            if (it.last_byte)
                clear_region();
        endfunction

        function void check_result(result_item_t got);
            result_item_t want;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none awaited, expected nothing, got found %0b offset %0d",
                         $time, got.found, got.match_offset);
                return;
            end
            want = awaited_results.pop_front();
            if (got.found !== want.found)
            begin
                errors++;
                $display("%0t: found mismatch, expected %0b, got %0b",
                         $time, want.found, got.found);
            end
            if (got.match_offset !== want.match_offset)
            begin
                errors++;
                $display("%0t: match_offset mismatch, expected %0d, got %0d",
                         $time, want.match_offset, got.match_offset);
            end
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   byte_valid   = 1'b0;
    logic                   byte_ready;
    byte_item_t             byte_item    = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_item_t           result_item;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    scan_scoreboard sb = new();

    // no_idle and hold_off_req are shared between the sender and the receiver process
    bit no_idle      = 1'b0;   // both sides run without gaps while set
    bit hold_off_req = 1'b0;   // receiver takes a long break after its next item
    int stall_cycles = 0;

    wildcard_byte_pattern_scanner_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // every handshake is observed here, in a fixed order per edge: register
    // writes first, then the byte, then the result, so the model never depends
    // on which process the simulator wakes first
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (byte_valid && byte_ready)
                sb.take_byte(byte_item);
            if (result_valid && result_ready)
                sb.check_result(result_item);
        end
    end

    // watchdog: ends the run if no channel moves an item for too long
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && byte_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stall before each result, plus one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    // one register write; cfg_valid stays up so back-to-back writes need one assignment per edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // loads every register; upper bits of the narrow registers carry junk on purpose
    task automatic program_scanner(input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                                   input logic [CFG_DATA_W-1:0] w2, input logic [CFG_DATA_W-1:0] w3,
                                   input logic [PAT_BYTES-1:0] mask, input logic [LEN_W-1:0] len,
                                   input bit spare);
        write_reg(REG_PATTERN_0, w0);
        write_reg(REG_PATTERN_1, w1);
        write_reg(REG_PATTERN_2, w2);
        write_reg(REG_PATTERN_3, w3);
        write_reg(REG_CARE_MASK, {$urandom, mask});
        write_reg(REG_PATTERN_LENGTH, {$urandom, 26'($urandom), len});
        if (spare)
        begin
            // indexes past the list must leave every register untouched
            write_reg(SPARE_INDEX_LO, {$urandom, $urandom});
            write_reg(SPARE_INDEX_HI, '1);
        end
        cfg_valid <= 1'b0;
    endtask

    // one byte item, with a random gap in front unless idling is off
    task automatic send_byte(input logic [7:0] d, input logic is_last);
        byte_item_t it;
        int         gap;
        it.data_byte = d;
        it.last_byte = is_last;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        do @(posedge clk); while (!byte_ready);
    endtask

    // called at the edge of the last accept so byte_valid gets one assignment there
    task automatic stop_bytes();
        byte_valid <= 1'b0;
    endtask

    // sender pause: waits until the scoreboard has seen the last accept, then for every
    // awaited result, then leaves room for a byte still in flight that produces nothing,
    // so a register write finds the block idle
    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one region, mostly built around the current pattern so matches and near
    // misses are common; some regions are plain noise
    task automatic send_region(inout int sent);
        logic [7:0] region_q [$];
        int         eff;
        int         len_r;
        int         start;
        bit         plant;
        bit         noisy;
        eff   = (sb.plen > PAT_BYTES) ? PAT_BYTES : int'(sb.plen);
        plant = ($urandom_range(0, 9) < 7);
        noisy = ($urandom_range(0, 3) == 0) || (eff == 0);
        if ($urandom_range(0, 9) == 0)
            len_r = $urandom_range(1, 64);
        else
            len_r = $urandom_range(1, eff + 8);
        for (int i = 0; i < len_r; i++)
        begin
            // background drawn from the pattern bytes makes partial matches likely
            if (!noisy && $urandom_range(0, 1))
                region_q = {region_q, sb.pat[$urandom_range(0, eff - 1)]};
            else
                region_q = {region_q, 8'($urandom)};
        end
        if (plant && eff > 0 && len_r >= eff)
        begin
            start = $urandom_range(0, len_r - eff);
            for (int j = 0; j < eff; j++)
                if (sb.care[j])
                    region_q[start + j] = sb.pat[j];
        end
        for (int i = 0; i < len_r; i++)
            send_byte(region_q[i], i == len_r - 1);
        sent += len_r;
    endtask

    // register settings per phase; the first few hit the extremes
    task automatic configure_phase(input int phase);
        logic [CFG_DATA_W-1:0] w [4];
        logic [PAT_BYTES-1:0]  mask;
        logic [LEN_W-1:0]      len;
        foreach (w[i]) w[i] = {$urandom, $urandom};
        mask = $urandom;
        if ($urandom_range(0, 3) == 0)
            mask = '1;
        len = LEN_W'($urandom_range(1, 12));
        if ($urandom_range(0, 4) == 0)
            len = LEN_W'($urandom_range(0, 63));
        case (phase)
            0:
            begin
                // length above 32 clamps
                mask = '1;
                len  = '1;
            end
            1:
            begin
                // all wildcards, full width
                mask = '0;
                len  = LEN_W'(PAT_BYTES);
            end
            2:
            begin
                w[0] = 64'hFF;
                mask = '1;
                len  = LEN_W'(1);
            end
            3: len = '0;                                       // zero length never matches
            4:
            begin
                foreach (w[i]) w[i] = '0;
                len = LEN_W'(33);
            end
            5:
            begin
                foreach (w[i]) w[i] = '1;
                mask = '1;
                len  = LEN_W'($urandom_range(1, 8));
            end
            default: ;
        endcase
        program_scanner(w[0], w[1], w[2], w[3], mask, len, $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        int total;
        int phase;
        int phase_sent;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // registers still at reset: zero length, so even an all-zero window must not match
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        stop_bytes();
        wait_drained();

        // pattern AB ?? CD, middle byte a wildcard, upper pattern words all ones
        program_scanner(64'h0000_0000_00CD_5AAB, '1, '1, '1, 32'h0000_0005, LEN_W'(3), 1'b1);
        // match at offset 1, then bytes after the match and a silent last byte
        send_byte(8'h11, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'hCD, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);
        // match completing on the last byte, at offset 0 of a fresh region
        send_byte(8'hAB, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hCD, 1'b1);
        // region shorter than the pattern, then a one-byte region: both not found
        send_byte(8'hAB, 1'b0);
        send_byte(8'hCD, 1'b1);
        send_byte(8'hFF, 1'b1);
        stop_bytes();
        wait_drained();

        // random phases: new settings only once the block has gone quiet
        total = 0;
        phase = 0;
        while (total < RANDOM_BYTES)
        begin
            configure_phase(phase);
            no_idle    = ($urandom_range(0, 3) == 0);
            phase_sent = 0;
            if (phase == 2)
            begin
                // back-pressure: receiver holds off while one-byte regions keep
                // coming, each with a result, until the block stalls its input
                no_idle      = 1'b1;
                hold_off_req = 1'b1;
                for (int i = 0; i < BURST_REGIONS; i++)
                    send_byte(8'($urandom), 1'b1);
                phase_sent = BURST_REGIONS;
                no_idle    = 1'b0;
            end
            while (phase_sent < PHASE_BYTES)
                send_region(phase_sent);
            total += phase_sent;
            stop_bytes();
            wait_drained();
            phase++;
        end

        // anything arriving now has no expectation and counts as a failure
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
